@@ hdl/software_timer_pool_assert.svh @@
// Assertion macros used by the timer pool top level.
`ifndef SOFTWARE_TIMER_POOL_ASSERT_SVH
`define SOFTWARE_TIMER_POOL_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define STP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer pool check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define STP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer pool check failed");

`else

`define STP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define STP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/stp_pkg.sv @@
// Types and constants of the software timer pool.
package stp_pkg;

    localparam int SLOTS      = 16;
    localparam int PORT_SLOTS = 16;
    localparam int ACTIVE     = (SLOTS < PORT_SLOTS) ? SLOTS : PORT_SLOTS;
    localparam int STEP_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int OP_W     = 3;
    localparam int TASK_W   = 8;
    localparam int DUR_W    = 32;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_SET    = 3'd1,
        OP_CANCEL = 3'd2,
        OP_RESET  = 3'd3,
        OP_DELETE = 3'd4,
        OP_RUN    = 3'd5,
        OP_CHECK  = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_EXPIRED = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [TASK_W-1:0] owner;
        logic [DUR_W-1:0]  remaining;
        logic [DUR_W-1:0]  reload;
        logic              rpt;
    } slot_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [TASK_W-1:0] task_id;
        logic [DUR_W-1:0]  duration_ms;
        logic              periodic;
        logic [SLOT_W-1:0] slot_index;
    } cmd_t;

    // Events raised by the head cell for the slot passing it this cycle.
    typedef struct packed {
        logic hit;
        logic take;
        logic used;
    } head_ev_t;

endpackage

@@ hdl/stp_if.sv @@
// Request and response channel interfaces of the timer pool.
interface stp_req_if import stp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [TASK_W-1:0] task_id;
    logic [DUR_W-1:0]  duration_ms;
    logic              periodic;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, opcode, task_id, duration_ms, periodic, slot_index,
                    input ready);
    modport sink   (input valid, opcode, task_id, duration_ms, periodic, slot_index,
                    output ready);
endinterface

interface stp_rsp_if import stp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [TASK_W-1:0]   fired_task;
    logic                in_use;
    logic                last;

    modport source (output valid, status, slot_out, fired_task, in_use, last,
                    input ready);
    modport sink   (input valid, status, slot_out, fired_task, in_use, last,
                    output ready);
endinterface

@@ hdl/stp_cell.sv @@
// One cell of the slot ring: holds a slot record and takes its neighbor's on advance.
module stp_cell import stp_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  slot_t d,
    output slot_t q
);

    slot_t rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else if (adv)
        begin
            rec_reg <= d;
        end
    end

    assign q = rec_reg;

endmodule

@@ hdl/stp_head.sv @@
// Head of the ring: applies the current command to the slot passing position zero.
module stp_head import stp_pkg::*; (
    input  slot_t             rec,
    input  cmd_t              cmd,
    input  logic [STEP_W-1:0] step,
    input  logic              found,
    output slot_t             rec_next,
    output head_ev_t          ev
);

    logic act;
    logic sel;

    assign act = (32'(step) < ACTIVE);
    assign sel = act && (32'(step) == 32'(cmd.slot_index));

    always_comb
    begin
        rec_next = rec;
        ev       = '0;
        if (act)
        begin
            unique case (cmd.opcode)
                OP_TICK:
                begin
                    if (rec.remaining != '0)
                    begin
                        rec_next.remaining = rec.remaining - DUR_W'(1);
                    end
                end
                OP_SET:
                begin
                    // first free slot only
                    if (rec.owner == '0 && !found)
                    begin
                        rec_next.owner     = cmd.task_id;
                        rec_next.remaining = cmd.duration_ms;
                        rec_next.reload    = cmd.duration_ms;
                        rec_next.rpt       = cmd.periodic;
                        ev.take            = 1'b1;
                    end
                end
                OP_CANCEL:
                begin
                    if (rec.owner == cmd.task_id)
                    begin
                        rec_next = '0;
                    end
                end
                OP_RESET:
                begin
                    if (sel)
                    begin
                        rec_next.remaining = rec.reload;
                    end
                end
                OP_DELETE:
                begin
                    if (sel)
                    begin
                        rec_next = '0;
                    end
                end
                OP_RUN:
                begin
                    if (rec.owner != '0 && rec.remaining == '0)
                    begin
                        ev.hit = 1'b1;
                        if (rec.rpt)
                        begin
                            rec_next.remaining = rec.reload;
                        end
                        else
                        begin
                            rec_next = '0;
                        end
                    end
                end
                OP_CHECK:
                begin
                    if (sel)
                    begin
                        ev.used = (rec.owner != '0);
                    end
                end
                default:
                begin
                    rec_next = rec;
                end
            endcase
        end
    end

endmodule

@@ hdl/software_timer_pool.sv @@
// Top level of the software timer pool: slot ring, head cell and response control.
//
// req carries one command beat (opcode, task_id, duration_ms, periodic,
// slot_index); rsp carries result beats (status, slot_out, fired_task,
// in_use, last). Both channels move a beat when valid and ready are high.
// The slot records sit in a ring of SLOTS cells that rotates by one cell
// per cycle during a scan unless held; the head cell applies the command
// to the record passing it, so one full turn visits every slot in index
// order. req is ready only in idle, which is entered again in the cycle
// the final result is offered; no command starts before the last ends.
// Every command gives one result beat with last set, except run, which
// gives one beat per expired slot and sets last on the final one (or one
// none beat with last set if none expired). A run result is held until
// the next hit or the scan end so that last can be known; the ring holds
// while a new hit finds one held and rsp stalls a full output register.
// Reset (rst_n low, asynchronous) frees every slot and clears all counts.
module software_timer_pool import stp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    stp_req_if.sink   req,
    stp_rsp_if.source rsp
);

`include "software_timer_pool_assert.svh"

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SLOTS - 1);

    state_t state_reg;
    state_t state_next;

    cmd_t              cmd_reg;
    logic [STEP_W-1:0] step_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] set_slot_reg;
    logic              used_reg;
    logic              pend_valid_reg;
    logic [SLOT_W-1:0] pend_slot_reg;
    logic [TASK_W-1:0] pend_task_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   slot_out_reg;
    logic [TASK_W-1:0]   fired_task_reg;
    logic                in_use_reg;
    logic                last_reg;

    slot_t    ring [SLOTS];
    slot_t    head_next;
    head_ev_t ev;

    logic accept;
    logic out_free;
    logic adv;
    logic emit_pend;
    logic emit_fin;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // ring of slot cells; the tail takes the record processed at the head
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_ring
        slot_t d;
        if (i == SLOTS - 1)
        begin : g_tail
            assign d = head_next;
        end
        else
        begin : g_mid
            assign d = ring[i+1];
        end
        stp_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .d     (d),
            .q     (ring[i])
        );
    end

    stp_head u_head (
        .rec      (ring[0]),
        .cmd      (cmd_reg),
        .step     (step_reg),
        .found    (found_reg),
        .rec_next (head_next),
        .ev       (ev)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (adv && step_reg == LAST_STEP)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        req.ready = 1'b0;
        adv       = 1'b0;
        emit_pend = 1'b0;
        emit_fin  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
            end
            S_SCAN:
            begin
                // hold the ring while a new hit must push out a held result and rsp stalls
                adv       = !(ev.hit && pend_valid_reg && !out_free);
                emit_pend = ev.hit && pend_valid_reg && out_free;
            end
            S_FINISH:
            begin
                emit_fin = out_free;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            used_reg       <= 1'b0;
            step_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                step_reg       <= '0;
                found_reg      <= 1'b0;
                used_reg       <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            else if (adv)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (ev.take)
                begin
                    found_reg <= 1'b1;
                end
                if (ev.used)
                begin
                    used_reg <= 1'b1;
                end
                if (ev.hit)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end

            if (emit_pend || emit_fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.opcode      <= req.opcode;
            cmd_reg.task_id     <= req.task_id;
            cmd_reg.duration_ms <= req.duration_ms;
            cmd_reg.periodic    <= req.periodic;
            cmd_reg.slot_index  <= req.slot_index;
        end

        if (adv && ev.take)
        begin
            set_slot_reg <= SLOT_W'(step_reg);
        end

        if (adv && ev.hit)
        begin
            pend_slot_reg <= SLOT_W'(step_reg);
            pend_task_reg <= ring[0].owner;
        end

        if (emit_pend)
        begin
            status_reg     <= ST_EXPIRED;
            slot_out_reg   <= pend_slot_reg;
            fired_task_reg <= pend_task_reg;
            in_use_reg     <= 1'b0;
            last_reg       <= 1'b0;
        end
        else if (emit_fin)
        begin
            in_use_reg <= (cmd_reg.opcode == OP_CHECK) && used_reg;
            last_reg   <= 1'b1;
            if (cmd_reg.opcode == OP_SET && found_reg)
            begin
                status_reg     <= ST_DONE;
                slot_out_reg   <= set_slot_reg;
                fired_task_reg <= '0;
            end
            else if (cmd_reg.opcode == OP_SET)
            begin
                status_reg     <= ST_NO_FREE;
                slot_out_reg   <= '0;
                fired_task_reg <= '0;
            end
            else if (cmd_reg.opcode == OP_RUN && pend_valid_reg)
            begin
                status_reg     <= ST_EXPIRED;
                slot_out_reg   <= pend_slot_reg;
                fired_task_reg <= pend_task_reg;
            end
            else if (cmd_reg.opcode == OP_RUN)
            begin
                status_reg     <= ST_NONE;
                slot_out_reg   <= '0;
                fired_task_reg <= '0;
            end
            else
            begin
                status_reg     <= ST_DONE;
                slot_out_reg   <= '0;
                fired_task_reg <= '0;
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.slot_out   = slot_out_reg;
    assign rsp.fired_task = fired_task_reg;
    assign rsp.in_use     = in_use_reg;
    assign rsp.last       = last_reg;

    `STP_ASSERT_NEXT(a_scan_ends, clk, rst_n,
        (state_reg == S_SCAN && adv && step_reg == LAST_STEP), (state_reg == S_FINISH))
    `STP_ASSERT_IMPLY(a_stall_only_run, clk, rst_n,
        (state_reg == S_SCAN && !adv),
        (cmd_reg.opcode == OP_RUN && pend_valid_reg && out_valid_reg))
    `STP_ASSERT_IMPLY(a_single_emit, clk, rst_n,
        (emit_pend || emit_fin), (out_free && !(emit_pend && emit_fin)))

endmodule

@@ sim/tb_software_timer_pool.sv @@
// Self-checking testbench of the software timer pool: directed and random commands checked against a slot table.
module tb_software_timer_pool;
    import stp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_SPARE = 3'd7;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [TASK_W-1:0] fired;
        logic              used;
        logic              last;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    stp_req_if req_ch ();
    stp_rsp_if rsp_ch ();

    software_timer_pool i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Expected slot table
    logic [TASK_W-1:0] slot_owner  [SLOTS];
    logic [DUR_W-1:0]  slot_count  [SLOTS];
    logic [DUR_W-1:0]  slot_reload [SLOTS];
    logic              slot_rpt    [SLOTS];

    cmd_t  cmd_backlog[$];
    beat_t due_beats[$];
    cmd_t  cmd_on_bus;

    int errors = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic rx_hold_arm = 1'b0;
    int rx_hold_left = 0;

    always #5 clk = ~clk;

    function automatic beat_t mk_beat(status_t st, int slot, logic [TASK_W-1:0] fired,
                                      logic used, logic last);
        beat_t b;
        b.status = st;
        b.slot   = SLOT_W'(slot);
        b.fired  = fired;
        b.used   = used;
        b.last   = last;
        return b;
    endfunction

    function automatic void clear_entry(int s);
        slot_owner[s]  = '0;
        slot_count[s]  = '0;
        slot_reload[s] = '0;
        slot_rpt[s]    = 1'b0;
    endfunction

    // Apply one command to the slot table and queue the beats it must produce.
    function automatic void step_timer_table(cmd_t c);
        bit hit [SLOTS];
        int n;
        int found;
        logic in_range;
        n = 0;
        found = -1;
        in_range = int'(c.slot_index) < ACTIVE;
        case (c.opcode)
            OP_TICK: begin
                for (int s = 0; s < ACTIVE; s++)
                    if (slot_count[s] != '0)
                        slot_count[s] = slot_count[s] - 1;
                due_beats.push_back(mk_beat(ST_DONE, 0, '0, 1'b0, 1'b1));
            end
            OP_SET: begin
                for (int s = 0; s < ACTIVE; s++)
                    if (found < 0 && slot_owner[s] == '0)
                        found = s;
                if (found >= 0) begin
                    slot_count[found]  = c.duration_ms;
                    slot_reload[found] = c.duration_ms;
                    slot_rpt[found]    = c.periodic;
                    slot_owner[found]  = c.task_id;
                    due_beats.push_back(mk_beat(ST_DONE, found, '0, 1'b0, 1'b1));
                end else begin
                    due_beats.push_back(mk_beat(ST_NO_FREE, 0, '0, 1'b0, 1'b1));
                end
            end
            OP_CANCEL: begin
                for (int s = 0; s < ACTIVE; s++)
                    if (slot_owner[s] == c.task_id)
                        clear_entry(s);
                due_beats.push_back(mk_beat(ST_DONE, 0, '0, 1'b0, 1'b1));
            end
            OP_RESET: begin
                if (in_range)
                    slot_count[c.slot_index] = slot_reload[c.slot_index];
                due_beats.push_back(mk_beat(ST_DONE, 0, '0, 1'b0, 1'b1));
            end
            OP_DELETE: begin
                if (in_range)
                    clear_entry(int'(c.slot_index));
                due_beats.push_back(mk_beat(ST_DONE, 0, '0, 1'b0, 1'b1));
            end
            OP_RUN: begin
                for (int s = 0; s < ACTIVE; s++) begin
                    hit[s] = slot_owner[s] != '0 && slot_count[s] == '0;
                    if (hit[s]) begin
                        due_beats.push_back(mk_beat(ST_EXPIRED, s, slot_owner[s], 1'b0, 1'b0));
                        n++;
                    end
                end
                if (n == 0) begin
                    due_beats.push_back(mk_beat(ST_NONE, 0, '0, 1'b0, 1'b1));
                end else begin
                    due_beats[due_beats.size() - 1].last = 1'b1;
                    for (int s = 0; s < ACTIVE; s++)
                        if (hit[s]) begin
                            if (slot_rpt[s])
                                slot_count[s] = slot_reload[s];
                            else
                                clear_entry(s);
                        end
                end
            end
            OP_CHECK: begin
                due_beats.push_back(mk_beat(ST_DONE, 0, '0,
                    in_range && slot_owner[c.slot_index] != '0, 1'b1));
            end
            default: begin
                due_beats.push_back(mk_beat(ST_DONE, 0, '0, 1'b0, 1'b1));
            end
        endcase
    endfunction

    function automatic void queue_cmd(logic [OP_W-1:0] op, logic [TASK_W-1:0] tid,
                                      logic [DUR_W-1:0] dur, logic per,
                                      logic [SLOT_W-1:0] idx);
        cmd_t c;
        c.opcode      = op;
        c.task_id     = tid;
        c.duration_ms = dur;
        c.periodic    = per;
        c.slot_index  = idx;
        cmd_backlog.push_back(c);
    endfunction

    // Mostly small counts and few owners so that timers expire and cancels bite.
    function automatic cmd_t rand_cmd();
        cmd_t c;
        int pick;
        int dsel;
        pick = $urandom_range(99);
        dsel = $urandom_range(99);
        c.task_id = ($urandom_range(9) < 7) ? TASK_W'($urandom_range(4, 1))
                                            : TASK_W'($urandom);
        if (dsel < 70)
            c.duration_ms = DUR_W'($urandom_range(4));
        else if (dsel < 90)
            c.duration_ms = DUR_W'($urandom_range(20));
        else
            c.duration_ms = DUR_W'($urandom);
        c.periodic   = 1'($urandom_range(1));
        c.slot_index = SLOT_W'($urandom_range(15));
        if (pick < 30)
            c.opcode = OP_SET;
        else if (pick < 55)
            c.opcode = OP_TICK;
        else if (pick < 70)
            c.opcode = OP_RUN;
        else if (pick < 78)
            c.opcode = OP_CHECK;
        else if (pick < 85)
            c.opcode = OP_RESET;
        else if (pick < 92)
            c.opcode = OP_DELETE;
        else if (pick < 97)
            c.opcode = OP_CANCEL;
        else
            c = cmd_t'(48'({$urandom, $urandom}));
        return c;
    endfunction

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || req_ch.valid || due_beats.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random_phase(int count);
        for (int i = 0; i < count; i++) begin
            // insert a run of sets that overflows the pool
            if (i == count / 2)
                for (int k = 0; k < ACTIVE + 1; k++)
                    queue_cmd(OP_SET, TASK_W'($urandom_range(255, 1)),
                              DUR_W'($urandom_range(6)), 1'($urandom_range(1)), '0);
            cmd_backlog.push_back(rand_cmd());
        end
    endtask

    initial begin
        req_ch.valid       = 1'b0;
        req_ch.opcode      = '0;
        req_ch.task_id     = '0;
        req_ch.duration_ms = '0;
        req_ch.periodic    = 1'b0;
        req_ch.slot_index  = '0;
        rsp_ch.ready       = 1'b0;
        for (int s = 0; s < SLOTS; s++)
            clear_entry(s);
    end

    // Request driver: hold the beat until accepted, then offer the next one.
    always @(posedge clk) begin : req_driver
        logic offer;
        offer = 1'b0;
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready)
                step_timer_table(cmd_on_bus);
            if (req_ch.valid && !req_ch.ready) begin
                offer = 1'b1;
            end else if (cmd_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                cmd_on_bus = cmd_backlog.pop_front();
                offer = 1'b1;
                req_ch.opcode      <= cmd_on_bus.opcode;
                req_ch.task_id     <= cmd_on_bus.task_id;
                req_ch.duration_ms <= cmd_on_bus.duration_ms;
                req_ch.periodic    <= cmd_on_bus.periodic;
                req_ch.slot_index  <= cmd_on_bus.slot_index;
            end
        end
        req_ch.valid <= offer;
    end

    // Long receiver hold-off, counted here once armed.
    always @(posedge clk) begin
        if (rx_hold_left > 0)
            rx_hold_left <= rx_hold_left - 1;
        else if (rx_hold_arm)
            rx_hold_left <= RX_HOLD_CYCLES;
    end

    // Response monitor: compare each beat with the oldest expected one.
    always @(posedge clk) begin : rsp_monitor
        beat_t want;
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (due_beats.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat: status %0d slot %0d task %0d used %0d last %0d",
                                 rsp_ch.status, rsp_ch.slot_out, rsp_ch.fired_task,
                                 rsp_ch.in_use, rsp_ch.last);
                end else begin
                    want = due_beats.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.slot_out !== want.slot ||
                        rsp_ch.fired_task !== want.fired || rsp_ch.in_use !== want.used ||
                        rsp_ch.last !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp status %0d slot %0d task %0d used %0d last %0d,",
                                     want.status, want.slot, want.fired, want.used, want.last,
                                     " got status %0d slot %0d task %0d used %0d last %0d",
                                     rsp_ch.status, rsp_ch.slot_out, rsp_ch.fired_task,
                                     rsp_ch.in_use, rsp_ch.last);
                    end
                end
            end
            rsp_ch.ready <= rx_hold_left == 0 && $urandom_range(99) >= rx_idle_pct;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle_pct = 28;
        rx_idle_pct = 49;

        // directed
        queue_cmd(OP_SET, 8'd255, 32'hFFFF_FFFF, 1'b1, 4'd0);
        queue_cmd(OP_SET, 8'd0, 32'd0, 1'b0, 4'd0);          // owner zero: stays free
        queue_cmd(OP_CHECK, 8'd0, 32'd0, 1'b0, 4'd0);
        queue_cmd(OP_CHECK, 8'd0, 32'd0, 1'b0, 4'd1);
        queue_cmd(OP_CHECK, 8'd0, 32'd0, 1'b0, 4'd15);
        queue_cmd(OP_RUN, 8'd0, 32'd0, 1'b0, 4'd0);
        queue_cmd(OP_SET, 8'd7, 32'd0, 1'b1, 4'd0);          // periodic, reload zero
        queue_cmd(OP_RUN, 8'd0, 32'd0, 1'b0, 4'd0);
        queue_cmd(OP_RUN, 8'd0, 32'd0, 1'b0, 4'd0);
        queue_cmd(OP_TICK, 8'd0, 32'd0, 1'b0, 4'd0);
        queue_cmd(OP_RESET, 8'd0, 32'd0, 1'b0, 4'd0);
        queue_cmd(OP_SET, 8'd200, 32'd1, 1'b0, 4'd0);
        queue_cmd(OP_TICK, 8'd0, 32'd0, 1'b0, 4'd0);
        queue_cmd(OP_RUN, 8'd0, 32'd0, 1'b0, 4'd0);
        queue_cmd(OP_DELETE, 8'd0, 32'd0, 1'b0, 4'd1);
        queue_cmd(OP_CANCEL, 8'd0, 32'd0, 1'b0, 4'd0);       // clears free slots
        queue_cmd(OP_CANCEL, 8'd255, 32'd0, 1'b0, 4'd0);
        queue_cmd(OP_SPARE, 8'hFF, 32'hFFFF_FFFF, 1'b1, 4'hF);
        queue_cmd(OP_RUN, 8'd0, 32'd0, 1'b0, 4'd0);
        queue_cmd(OP_RESET, 8'd0, 32'd0, 1'b0, 4'd15);
        queue_cmd(OP_DELETE, 8'd0, 32'd0, 1'b0, 4'd15);
        wait_drained();

        // stall the receiver while the sender keeps offering
        rx_hold_arm = 1'b1;
        @(negedge clk);
        rx_hold_arm = 1'b0;
        run_random_phase(55);
        wait_drained();

        tx_idle_pct = 49;
        rx_idle_pct = 28;
        run_random_phase(55);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_phase(55);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && due_beats.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ software_timer_pool.f @@
+incdir+hdl
hdl/stp_pkg.sv
hdl/stp_if.sv
hdl/stp_cell.sv
hdl/stp_head.sv
hdl/software_timer_pool.sv
sim/tb_software_timer_pool.sv
